### rtl/tlbw_pkg.sv
`default_nettype none
package tlbw_pkg;

  localparam int MAX_LAYERS = 4;
  localparam int TANH_DEPTH = 256;
  localparam int TANH_IDX_W = $clog2(TANH_DEPTH);

  localparam logic [15:0] ONE_Q15  = 16'd32768;
  localparam logic [15:0] HALF_Q15 = 16'd16384;

  // slope / (pi/4) with pi = 355/113: n = s * 904 / 355
  localparam logic [9:0]  SLOPE_MUL   = 10'd904;
  localparam logic [8:0]  SLOPE_DIV   = 9'd355;
  localparam logic [23:0] SLOPE_RECIP = 24'd12098499; // floor(2^32 / 355)
  localparam logic [15:0] SLOPE_SAT   = 16'd12868;    // first slope that clamps to one

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_MIN_HEIGHT  = 3'd1,
    REG_MAX_HEIGHT  = 3'd2,
    REG_LAYER_ZERO  = 3'd3,
    REG_LAYER_ONE   = 3'd4,
    REG_LAYER_TWO   = 3'd5,
    REG_LAYER_THREE = 3'd6
  } reg_index_t;

  // Load bundle into the normalizer
  typedef struct packed {
    logic              valid;
    logic [17:0]       total;
    logic [3:0][15:0]  c;
  } norm_in_t;

  typedef logic [15:0] tanh_tab_t [TANH_DEPTH];

  // Restoring long division, used only while building the table
  function automatic logic [63:0] div_u64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      if (r >= b) begin
        r = r - b;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build tanh(4*i/DEPTH) in Q1.15 with the integer exp series
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    longint      sum;
    for (int i = 0; i < TANH_DEPTH; i++) begin
      u    = (64'(i) << 30) >> TANH_IDX_W;
      term = 64'd1 << 30;
      sum  = longint'(64'd1 << 30);
      for (int k = 1; k <= 20; k++) begin
        term = div_u64(term * u, 64'(k)) >> 30;
        if ((k & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = 64'(sum);
      if (e > (64'd1 << 30)) e = 64'd1 << 30;
      for (int k = 0; k < 3; k++) e = (e * e + (64'd1 << 29)) >> 30;
      num = ((64'd1 << 30) - e) << 15;
      den = (64'd1 << 30) + e;
      tab[i] = 16'(div_u64(num + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage
`default_nettype wire

### rtl/tlbw_norm.sv
`default_nettype none
module tlbw_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  tlbw_pkg::norm_in_t   load,
  output logic                 valid,
  output logic [3:0][15:0]     w
);

  localparam int NST = 17;

  logic [30:0] rem    [NST][4];
  logic [30:0] rem_nx [NST][4];
  logic [15:0] q      [NST][4];
  logic [15:0] q_nx   [NST][4];
  logic [17:0] tot    [NST];
  logic        zero   [NST];
  logic        v      [NST];

  // One quotient bit per stage, restoring
  always_comb begin
    logic [33:0] dv;
    for (int k = 0; k < NST; k++) begin
      for (int i = 0; i < 4; i++) begin
        rem_nx[k][i] = '0;
        q_nx[k][i]   = '0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      rem_nx[0][i] = {load.c[i], 15'd0} + 31'(load.total[17:1]);
    end
    for (int k = 1; k < NST; k++) begin
      for (int i = 0; i < 4; i++) begin
        dv = 34'(tot[k-1]) << (NST - 1 - k);
        rem_nx[k][i] = rem[k-1][i];
        q_nx[k][i]   = q[k-1][i];
        if ({3'd0, rem[k-1][i]} >= dv) begin
          rem_nx[k][i] = 31'({3'd0, rem[k-1][i]} - dv);
          q_nx[k][i][NST - 1 - k] = 1'b1;
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= load.valid;
      for (int k = 1; k < NST; k++) v[k] <= v[k-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      tot[0]  <= load.total;
      zero[0] <= (load.total == 18'd0);
      for (int k = 1; k < NST; k++) begin
        tot[k]  <= tot[k-1];
        zero[k] <= zero[k-1];
      end
      for (int k = 0; k < NST; k++) begin
        for (int i = 0; i < 4; i++) begin
          rem[k][i] <= rem_nx[k][i];
          q[k][i]   <= q_nx[k][i];
        end
      end
    end
  end

  // Zero total selects layer zero only
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (zero[NST-1]) w[i] = (i == 0) ? tlbw_pkg::ONE_Q15 : 16'd0;
      else w[i] = q[NST-1][i];
    end
  end

  assign valid = v[NST-1];

endmodule
`default_nettype wire

### rtl/terrain_layer_blend_weights.sv
`default_nettype none
// Channel   Handshake                    Payload
// cfg       cfg_write                    cfg_index, cfg_data
// sample    sample_valid / sample_stall  sample_height, sample_slope
// weight    weight_valid / weight_stall  weight_zero .. weight_three
//
// One sample enters per cycle while no result is stalled; results pass through the
// 8-step height divider and the 16-step normalizing divider pipelines.
// Synchronous rst clears configuration and all valid bits.
// A stalled result freezes the whole pipeline; sample_stall follows it.
module terrain_layer_blend_weights (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [23:0] sample_height,
  input  logic [15:0]        sample_slope,
  output logic               weight_valid,
  input  logic               weight_stall,
  output logic [15:0]        weight_zero,
  output logic [15:0]        weight_one,
  output logic [15:0]        weight_two,
  output logic [15:0]        weight_three
);

  // Configuration
  logic [2:0]         layer_count;
  logic signed [23:0] min_height;
  logic signed [23:0] max_height;
  logic [63:0]        layer_set [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= '0;
      min_height  <= '0;
      max_height  <= '0;
      for (int i = 0; i < 4; i++) layer_set[i] <= '0;
    end else if (cfg_write) begin
      case (tlbw_pkg::reg_index_t'(cfg_index))
        tlbw_pkg::REG_LAYER_COUNT: layer_count  <= cfg_data[2:0];
        tlbw_pkg::REG_MIN_HEIGHT:  min_height   <= cfg_data[23:0];
        tlbw_pkg::REG_MAX_HEIGHT:  max_height   <= cfg_data[23:0];
        tlbw_pkg::REG_LAYER_ZERO:  layer_set[0] <= cfg_data;
        tlbw_pkg::REG_LAYER_ONE:   layer_set[1] <= cfg_data;
        tlbw_pkg::REG_LAYER_TWO:   layer_set[2] <= cfg_data;
        tlbw_pkg::REG_LAYER_THREE: layer_set[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode layer settings (the user keeps them stable while items flow; not enforced here)
  logic [2:0]  n_act;
  logic        step_mode;
  logic        active [4];
  logic [23:0] bh     [4];
  logic [23:0] bw     [4];
  logic [23:0] abw    [4];
  logic        bwneg  [4];
  logic        step_l [4];
  logic [15:0] fac    [4];
  logic [24:0] range_d;

  always_comb begin
    n_act     = (layer_count > 3'(tlbw_pkg::MAX_LAYERS)) ?
                3'(tlbw_pkg::MAX_LAYERS) : layer_count;
    range_d   = {max_height[23], max_height} - {min_height[23], min_height};
    step_mode = range_d[24] || (range_d == 25'd0);
    for (int i = 0; i < 4; i++) begin
      active[i] = (3'(i) < n_act);
      bh[i]     = layer_set[i][23:0];
      bw[i]     = layer_set[i][47:24];
      bwneg[i]  = bw[i][23];
      abw[i]    = bwneg[i] ? 24'(-bw[i]) : bw[i];
      step_l[i] = step_mode || (bw[i] == 24'd0);
      fac[i]    = (layer_set[i][63:48] > tlbw_pkg::ONE_Q15) ?
                  tlbw_pkg::ONE_Q15 : layer_set[i][63:48];
    end
  end

  // Pipeline enable
  logic en;
  assign en           = !(weight_valid && weight_stall);
  assign sample_stall = weight_valid && weight_stall;

  logic v [13];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 13; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= sample_valid;
      for (int k = 1; k < 13; k++) v[k] <= v[k-1];
    end
  end

  // Height distance and divider stages
  logic [30:0] hrem    [9][4];
  logic [30:0] hrem_nx [9][4];
  logic [7:0]  hq      [9][4];
  logic [7:0]  hq_nx   [9][4];
  logic        hneg    [9][4];
  logic        hneg_nx [4];
  logic        hsat    [9][4];
  logic        hsat_nx [4];

  always_comb begin
    logic [24:0] d;
    logic [23:0] ad;
    logic [30:0] dv;
    for (int k = 0; k < 9; k++) begin
      for (int i = 0; i < 4; i++) begin
        hrem_nx[k][i] = '0;
        hq_nx[k][i]   = '0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      d             = {sample_height[23], sample_height} - {bh[i][23], bh[i]};
      ad            = d[24] ? 24'(-d) : d[23:0];
      hneg_nx[i]    = d[24];
      hsat_nx[i]    = {1'b0, ad} >= {abw[i], 1'b0};
      hrem_nx[0][i] = {ad, 7'd0};
    end
    for (int k = 1; k < 9; k++) begin
      for (int i = 0; i < 4; i++) begin
        dv = 31'(abw[i]) << (8 - k);
        hrem_nx[k][i] = hrem[k-1][i];
        hq_nx[k][i]   = hq[k-1][i];
        if (hrem[k-1][i] >= dv) begin
          hrem_nx[k][i] = hrem[k-1][i] - dv;
          hq_nx[k][i][8 - k] = 1'b1;
        end
      end
    end
  end

  // Slope path: scale, reciprocal multiply, correct
  logic [23:0] s0_num;
  logic        s0_sat;
  logic [15:0] s1_q0;
  logic [23:0] s1_num;
  logic        s1_sat;
  logic [15:0] sn [2:8];
  logic [25:0] s_scaled;
  logic [47:0] s_prod;
  logic [23:0] s_rem;
  logic [15:0] s_n;

  always_comb begin
    s_scaled = 26'(sample_slope) * 26'(tlbw_pkg::SLOPE_MUL);
    s_prod   = 48'(s0_num) * 48'(tlbw_pkg::SLOPE_RECIP);
    s_rem    = s1_num - 24'(s1_q0 * 24'(tlbw_pkg::SLOPE_DIV));
    if (s1_sat) s_n = tlbw_pkg::ONE_Q15;
    else if (s_rem >= 24'(tlbw_pkg::SLOPE_DIV)) s_n = s1_q0 + 16'd1;
    else s_n = s1_q0;
  end

  // Height weight and slope weight
  logic [15:0] hw_nx [4];
  logic [15:0] sw_nx [4];

  always_comb begin
    logic [16:0] t;
    for (int i = 0; i < 4; i++) begin
      t = hsat[8][i] ? 17'(tlbw_pkg::ONE_Q15) :
          17'(tlbw_pkg::TANH_TAB[hq[8][i]]);
      if (step_l[i]) hw_nx[i] = hneg[8][i] ? 16'd0 : tlbw_pkg::ONE_Q15;
      else if (hneg[8][i] != bwneg[i])
        hw_nx[i] = 16'((17'(tlbw_pkg::ONE_Q15) - t) >> 1);
      else
        hw_nx[i] = 16'((17'(tlbw_pkg::ONE_Q15) + t) >> 1);
      sw_nx[i] = (fac[i] > tlbw_pkg::HALF_Q15) ? sn[8] : tlbw_pkg::ONE_Q15 - sn[8];
    end
  end

  logic [15:0] hw9  [4];
  logic [15:0] sw9  [4];
  logic [30:0] p1   [4];
  logic [30:0] p2   [4];
  logic [15:0] c11  [4];
  logic [15:0] c12  [4];
  logic [17:0] total12;
  logic [30:0] mix  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mix[i] = p1[i] + p2[i] + 31'(tlbw_pkg::HALF_Q15);
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        for (int i = 0; i < 4; i++) begin
          hrem[k][i] <= hrem_nx[k][i];
          hq[k][i]   <= hq_nx[k][i];
        end
      end
      for (int i = 0; i < 4; i++) begin
        hneg[0][i] <= hneg_nx[i];
        hsat[0][i] <= hsat_nx[i];
        for (int k = 1; k < 9; k++) begin
          hneg[k][i] <= hneg[k-1][i];
          hsat[k][i] <= hsat[k-1][i];
        end
      end
      s0_num <= s_scaled[23:0];
      s0_sat <= (sample_slope >= tlbw_pkg::SLOPE_SAT);
      s1_q0  <= s_prod[47:32];
      s1_num <= s0_num;
      s1_sat <= s0_sat;
      sn[2]  <= s_n;
      for (int k = 3; k < 9; k++) sn[k] <= sn[k-1];
      for (int i = 0; i < 4; i++) begin
        hw9[i] <= hw_nx[i];
        sw9[i] <= sw_nx[i];
        p1[i]  <= 31'(32'(hw9[i]) * 32'(tlbw_pkg::ONE_Q15 - fac[i]));
        p2[i]  <= 31'(32'(sw9[i]) * 32'(fac[i]));
        c11[i] <= active[i] ? mix[i][30:15] : 16'd0;
        c12[i] <= c11[i];
      end
      total12 <= 18'(c11[0]) + 18'(c11[1]) + 18'(c11[2]) + 18'(c11[3]);
    end
  end

  // Normalize
  tlbw_pkg::norm_in_t nload;
  logic [3:0][15:0]   w;

  always_comb begin
    nload.valid = v[12];
    nload.total = total12;
    for (int i = 0; i < 4; i++) nload.c[i] = c12[i];
  end

  tlbw_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .load  (nload),
    .valid (weight_valid),
    .w     (w)
  );

  assign weight_zero  = w[0];
  assign weight_one   = w[1];
  assign weight_two   = w[2];
  assign weight_three = w[3];

  // Checks
  a_reset_clears: assert property (@(posedge clk) rst |=> !weight_valid)
    else $error("result valid after reset");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    weight_valid |-> (weight_zero <= tlbw_pkg::ONE_Q15) &&
      (weight_one <= tlbw_pkg::ONE_Q15) && (weight_two <= tlbw_pkg::ONE_Q15) &&
      (weight_three <= tlbw_pkg::ONE_Q15))
    else $error("weight above one");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    v[12] |-> (total12 <= 18'd131072))
    else $error("layer sum out of range");

endmodule
`default_nettype wire
